// File: design/vsv_pkg.sv
// Shared types and constants for the version string validator.
// Depends on nothing; used by the step logic and the top level.
package vsv_pkg;

    // Parse phases
    localparam logic [1:0] PH_CORE = 2'd0;  // major.minor.patch digits
    localparam logic [1:0] PH_LIT  = 2'd1;  // matching "-beta."
    localparam logic [1:0] PH_NUM  = 2'd2;  // beta number

    localparam int unsigned PART_W    = 16;
    localparam logic [PART_W+3:0] PART_MAX = 20'd65535;
    localparam logic [2:0] BETA_LEN   = 3'd6;
    localparam logic [1:0] LAST_PART  = 2'd2;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } vsv_in_t;

    typedef struct packed {
        logic valid_res;
    } vsv_out_t;

    // Parse state, less the character count (its width follows MAX_LEN)
    typedef struct packed {
        logic [1:0]        phase;
        logic [1:0]        part_index;
        logic [PART_W-1:0] part_value;
        logic              digit_seen;
        logic [2:0]        literal_index;
        logic              failed;
    } vsv_state_t;

    localparam vsv_state_t STATE_CLEAR = '{
        phase:         PH_CORE,
        part_index:    2'd0,
        part_value:    '0,
        digit_seen:    1'b0,
        literal_index: 3'd0,
        failed:        1'b0
    };

    // Characters of "-beta." by position
    function automatic logic [7:0] beta_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h2D;  // '-'
            3'd1:    c = 8'h62;  // 'b'
            3'd2:    c = 8'h65;  // 'e'
            3'd3:    c = 8'h74;  // 't'
            3'd4:    c = 8'h61;  // 'a'
            3'd5:    c = 8'h2E;  // '.'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/vsv_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
// Depends on nothing; payload type is a parameter (types from vsv_pkg).
interface vsv_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// File: design/version_string_validator.sv
// Version string validator top level: input register, parse state, result register.
// Depends on vsv_pkg, vsv_stream_if and vsv_step.
//
// Takes one character per transaction on din (ch, last) and checks the string for
// major.minor.patch with an optional -beta.N suffix, each number 0..65535 and the
// whole string at most MAX_LEN characters. One result (valid_res) is given on dout
// for each character marked last. A character is accepted every cycle but for the
// stall below; the result of a last character goes into the result register. The
// single result register sets the only stall: a last character waiting in the input
// register holds it while an earlier result has not been taken.
module version_string_validator
    import vsv_pkg::*;
#(
    parameter int unsigned MAX_LEN = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    vsv_stream_if.sink          din,
    vsv_stream_if.source        dout
);

    localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

    vsv_in_t          in_reg;
    logic             in_vld_reg;
    vsv_state_t       st_reg;
    vsv_state_t       st_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_vld_reg;
    logic             res_reg;
    logic             ok;
    logic             advance;

    // non-last characters never wait for the output side
    assign advance   = in_vld_reg && (!in_reg.last || !out_vld_reg || dout.ready);
    assign din.ready = !in_vld_reg || advance;

    vsv_step #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_step (
        .cur     (st_reg),
        .cur_cnt (cnt_reg),
        .item    (in_reg),
        .nxt     (st_next),
        .nxt_cnt (cnt_next),
        .ok      (ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            st_reg      <= STATE_CLEAR;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (din.ready)
            begin
                in_vld_reg <= din.valid;
            end
            if (advance)
            begin
                st_reg  <= st_next;
                cnt_reg <= cnt_next;
            end
            if (advance && in_reg.last)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (din.ready && din.valid)
        begin
            in_reg <= din.data;
        end
        if (advance && in_reg.last)
        begin
            res_reg <= ok;
        end
    end

    assign dout.valid          = out_vld_reg;
    assign dout.data.valid_res = res_reg;

endmodule

// File: design/vsv_step.sv
// Combinational update of the parse state for one character.
// Depends on vsv_pkg.
module vsv_step
    import vsv_pkg::*;
#(
    parameter int unsigned MAX_LEN = 31,
    parameter int unsigned CNT_W   = $clog2(MAX_LEN + 1)
) (
    input  vsv_state_t       cur,
    input  logic [CNT_W-1:0] cur_cnt,
    input  vsv_in_t          item,
    output vsv_state_t       nxt,
    output logic [CNT_W-1:0] nxt_cnt,
    output logic             ok
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    vsv_state_t         s;
    logic [CNT_W-1:0]   cnt;
    logic               is_digit;
    logic [PART_W+3:0]  prod;

    assign is_digit = (item.ch inside {[8'h30:8'h39]});
    // value * 10 + digit
    assign prod = ({4'b0, cur.part_value} << 3) + ({4'b0, cur.part_value} << 1)
                + {16'b0, item.ch[3:0]};

    always_comb
    begin
        s   = cur;
        cnt = cur_cnt;
        if (!s.failed)
        begin
            if (cnt >= CNT_MAX)
            begin
                s.failed = 1'b1;
            end
            else
            begin
                cnt = cnt + CNT_W'(1);
                case (s.phase)
                    PH_CORE:
                    begin
                        if (is_digit)
                        begin
                            if (prod > PART_MAX)
                            begin
                                s.failed = 1'b1;
                            end
                            else
                            begin
                                s.part_value = prod[PART_W-1:0];
                                s.digit_seen = 1'b1;
                            end
                        end
                        else if (item.ch == CH_DOT && s.digit_seen && s.part_index < LAST_PART)
                        begin
                            s.part_index = s.part_index + 2'd1;
                            s.part_value = '0;
                            s.digit_seen = 1'b0;
                        end
                        else if (item.ch == CH_DASH && s.digit_seen
                                 && s.part_index == LAST_PART)
                        begin
                            s.phase         = PH_LIT;
                            s.literal_index = 3'd1;
                        end
                        else
                        begin
                            s.failed = 1'b1;
                        end
                    end
                    PH_LIT:
                    begin
                        if (s.literal_index < BETA_LEN
                            && item.ch == beta_char(s.literal_index))
                        begin
                            s.literal_index = s.literal_index + 3'd1;
                            if (s.literal_index == BETA_LEN)
                            begin
                                s.phase      = PH_NUM;
                                s.part_value = '0;
                                s.digit_seen = 1'b0;
                            end
                        end
                        else
                        begin
                            s.failed = 1'b1;
                        end
                    end
                    default:
                    begin
                        // beta number (unused code 3 behaves the same)
                        if (is_digit && prod <= PART_MAX)
                        begin
                            s.part_value = prod[PART_W-1:0];
                            s.digit_seen = 1'b1;
                        end
                        else
                        begin
                            s.failed = 1'b1;
                        end
                    end
                endcase
            end
        end

        ok = !s.failed && s.digit_seen
           && ((s.phase == PH_CORE && s.part_index == LAST_PART) || s.phase == PH_NUM);

        if (item.last)
        begin
            nxt     = STATE_CLEAR;
            nxt_cnt = '0;
        end
        else
        begin
            nxt     = s;
            nxt_cnt = cnt;
        end
    end

endmodule
